// ===== hdl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // access kinds
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic look;
        logic update;
        logic second;
        logic publish;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_fetch;
        logic is_modify;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/sacl_access_if.sv =====
// ----------------------------------------------------------------------------
// sacl_access_if
// Access channel: one word is a command and a byte address.
// ----------------------------------------------------------------------------
interface sacl_access_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink (input valid, input cmd, input address, output ready);
endinterface

// ===== hdl/sacl_result_if.sv =====
// ----------------------------------------------------------------------------
// sacl_result_if
// Result channel: hit/miss/evict flags and the running totals.
// ----------------------------------------------------------------------------
interface sacl_result_if;
    logic        valid;
    logic        ready;
    logic        was_hit;
    logic        was_miss;
    logic        did_evict;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;

    modport source (output valid, output was_hit, output was_miss, output did_evict,
                    output hit_total, output miss_total, output evict_total,
                    input ready);
    modport sink (input valid, input was_hit, input was_miss, input did_evict,
                  input hit_total, input miss_total, input evict_total,
                  output ready);
endinterface

// ===== hdl/sacl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sacl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sacl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [4:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/set_assoc_cache_lru_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache model with LRU replacement and saturating
// hit/miss/eviction counters.
// ----------------------------------------------------------------------------
// One access word at a time. A load or store passes the accept, lookup,
// write-back and result states, a modify adds a second write-back of the
// same row and an instruction fetch skips the write-back; the result
// register is loaded in the result state, which waits only while the
// previous result still sits in the output register. Each load, store or
// modify is a read-modify-write of one set row in the row RAM: read, tag
// match and LRU compare, pick and write-back.
// Each set row holds all ways (valid, tag, stamp); a flip-flop per set marks
// rows never written, which read as empty, so no clearing pass is needed
// after reset. A finished result waits in the output register while the next
// word is accepted. Configuration writes are taken at any time but must only
// be issued while no access is in flight.
module set_assoc_cache_lru_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input logic          clk,
    input logic          rst_n,
    sacl_access_if.sink  access,
    sacl_result_if.source result,
    sacl_cfg_if.sink     cfg
);

    ctl_t ctl;
    sts_t sts;
    logic in_ready;

    assign access.ready = in_ready;
    assign cfg.ready    = 1'b1;

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (access.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    sacl_dpath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .in_cmd          (access.cmd),
        .in_address      (access.address),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_was_hit     (result.was_hit),
        .out_was_miss    (result.was_miss),
        .out_did_evict   (result.did_evict),
        .out_hit_total   (result.hit_total),
        .out_miss_total  (result.miss_total),
        .out_evict_total (result.evict_total)
    );

    // only one access in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (access.valid && access.ready) |=> !access.ready)
        else $error("access accepted while another is in flight");

    // a new result only follows a word in flight
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> !$past(access.ready))
        else $error("result appeared with no access in flight");

    // an eviction is always part of a miss
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.did_evict) |-> (result.was_miss && !result.was_hit))
        else $error("eviction flagged without a miss");

endmodule

// ===== hdl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: accept, look up the set, update the row (not for a fetch),
// second touch for a modify, then hand the result to the output register.
// ----------------------------------------------------------------------------
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_SECOND = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = sts.is_fetch ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctl.update = 1'b1;
                state_next = sts.is_modify ? ST_SECOND : ST_DONE;
            end
            ST_SECOND:
            begin
                ctl.second = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sacl_dpath.sv =====
// ----------------------------------------------------------------------------
// sacl_dpath
// Address split, set row storage, tag match, LRU pick, row write-back,
// saturating counters and the result register.
// ----------------------------------------------------------------------------
module sacl_dpath
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [ADDR_W-1:0]     in_address,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_was_hit,
    output logic                  out_was_miss,
    output logic                  out_did_evict,
    output logic [CNT_W-1:0]      out_hit_total,
    output logic [CNT_W-1:0]      out_miss_total,
    output logic [CNT_W-1:0]      out_evict_total
);

    localparam int NUM_SETS = 2 ** MAX_SET_BITS;
    localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W    = MAX_WAYS * $bits(line_t);

    // configuration
    logic [2:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd0;
            block_bits_reg <= 5'd0;
            ways_used_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                CFG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // address split
    logic [3:0]        s_eff;
    logic [5:0]        tag_shift;
    logic [ADDR_W-1:0] set_mask;
    logic [ADDR_W-1:0] set_full;
    logic [SET_AW-1:0] set_now;
    logic [TAG_W-1:0]  tag_now;

    assign s_eff     = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                              : 4'(set_bits_reg);
    assign tag_shift = 6'(block_bits_reg) + 6'(s_eff);
    assign set_mask  = (32'd1 << s_eff) - 32'd1;
    assign set_full  = (in_address >> block_bits_reg) & set_mask;
    assign set_now   = set_full[SET_AW-1:0];
    assign tag_now   = in_address >> tag_shift;

    // ways in use
    logic [4:0]          ways_eff;
    logic [MAX_WAYS-1:0] used;

    always_comb
    begin
        if (ways_used_reg == 4'd0)
        begin
            ways_eff = 5'd1;
        end
        else if (5'(ways_used_reg) > 5'(MAX_WAYS))
        begin
            ways_eff = 5'(MAX_WAYS);
        end
        else
        begin
            ways_eff = 5'(ways_used_reg);
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            used[w] = 5'(w) < ways_eff;
        end
    end

    // captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [SET_AW-1:0] set_reg;
    logic [TAG_W-1:0]  tag_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= in_cmd;
            set_reg <= set_now;
            tag_reg <= tag_now;
        end
    end

    assign sts.is_fetch  = cmd_reg == CMD_FETCH;
    assign sts.is_modify = cmd_reg == CMD_MODIFY;
    assign sts.out_free  = !out_valid || out_ready;

    // row storage; a set not yet written reads as all lines invalid, stamp zero
    logic [NUM_SETS-1:0]  row_init_reg;
    logic [ROW_W-1:0]     ram_rdata;
    line_t [MAX_WAYS-1:0] row_rd;
    line_t [MAX_WAYS-1:0] row_reg;
    line_t [MAX_WAYS-1:0] row_wr;
    logic                 ram_we;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (ctl.capture),
        .raddr (set_now),
        .rdata (ram_rdata)
    );

    assign row_rd = row_init_reg[set_reg] ? ram_rdata : '0;

    // lookup: tag match, free lines, LRU candidate (lowest stamp, lowest way on ties)
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] lru_vec;
    logic [MAX_WAYS-1:0] hit_vec_reg;
    logic [MAX_WAYS-1:0] inv_vec_reg;
    logic [MAX_WAYS-1:0] lru_vec_reg;

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w] = used[w] && row_rd[w].valid && (row_rd[w].tag == tag_reg);
            inv_vec[w] = used[w] && !row_rd[w].valid;
            lru_vec[w] = used[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (v < w && used[v] && !(row_rd[w].stamp < row_rd[v].stamp))
                begin
                    lru_vec[w] = 1'b0;
                end
                if (v > w && used[v] && !(row_rd[w].stamp <= row_rd[v].stamp))
                begin
                    lru_vec[w] = 1'b0;
                end
            end
        end
    end

    // lowest set bit of each vector
    logic [WAY_IW-1:0] hit_way;
    logic [WAY_IW-1:0] inv_way;
    logic [WAY_IW-1:0] lru_way;

    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec_reg[w])
            begin
                hit_way = WAY_IW'(w);
            end
            if (inv_vec_reg[w])
            begin
                inv_way = WAY_IW'(w);
            end
            if (lru_vec_reg[w])
            begin
                lru_way = WAY_IW'(w);
            end
        end
    end

    logic              any_hit;
    logic              any_inv;
    logic [WAY_IW-1:0] way_sel;
    logic [WAY_IW-1:0] way_reg;
    logic [WAY_IW-1:0] touch_way;

    assign any_hit   = |hit_vec_reg;
    assign any_inv   = |inv_vec_reg;
    assign way_sel   = any_hit ? hit_way : (any_inv ? inv_way : lru_way);
    assign touch_way = ctl.update ? way_sel : way_reg;
    assign ram_we    = ctl.update || ctl.second;

    // stamp clock skips zero on wrap
    logic [STAMP_W-1:0] stamp_clock_reg;
    logic [STAMP_W-1:0] stamp_touch;

    assign stamp_touch = (stamp_clock_reg == '1) ? STAMP_W'(1) : stamp_clock_reg + 1'b1;

    always_comb
    begin
        row_wr = row_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_IW'(w) == touch_way)
            begin
                row_wr[w].valid = 1'b1;
                row_wr[w].tag   = tag_reg;
                row_wr[w].stamp = stamp_touch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            row_reg     <= row_rd;
            hit_vec_reg <= hit_vec;
            inv_vec_reg <= inv_vec;
            lru_vec_reg <= lru_vec;
        end
        else if (ctl.update)
        begin
            row_reg <= row_wr;
            way_reg <= way_sel;
        end
    end

    // counters and per-item flags
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] evict_cnt_reg;
    logic             hit_reg;
    logic             miss_reg;
    logic             evict_reg;
    logic [CNT_W-1:0] hit_inc;
    logic [CNT_W-1:0] miss_inc;
    logic [CNT_W-1:0] evict_inc;

    assign hit_inc   = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
    assign miss_inc  = (miss_cnt_reg == '1) ? miss_cnt_reg : miss_cnt_reg + 1'b1;
    assign evict_inc = (evict_cnt_reg == '1) ? evict_cnt_reg : evict_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_init_reg    <= '0;
            stamp_clock_reg <= STAMP_W'(1);
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            evict_cnt_reg   <= '0;
            hit_reg         <= 1'b0;
            miss_reg        <= 1'b0;
            evict_reg       <= 1'b0;
            out_valid       <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                hit_reg   <= 1'b0;
                miss_reg  <= 1'b0;
                evict_reg <= 1'b0;
            end
            if (ram_we)
            begin
                row_init_reg[set_reg] <= 1'b1;
                stamp_clock_reg       <= stamp_touch;
            end
            if (ctl.update)
            begin
                hit_reg   <= any_hit;
                miss_reg  <= !any_hit;
                evict_reg <= !any_hit && !any_inv;
                if (any_hit)
                begin
                    hit_cnt_reg <= hit_inc;
                end
                else
                begin
                    miss_cnt_reg <= miss_inc;
                    if (!any_inv)
                    begin
                        evict_cnt_reg <= evict_inc;
                    end
                end
            end
            // second half of a modify always hits
            if (ctl.second)
            begin
                hit_cnt_reg <= hit_inc;
            end
            if (ctl.publish)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.publish)
        begin
            out_was_hit     <= hit_reg;
            out_was_miss    <= miss_reg;
            out_did_evict   <= evict_reg;
            out_hit_total   <= hit_cnt_reg;
            out_miss_total  <= miss_cnt_reg;
            out_evict_total <= evict_cnt_reg;
        end
    end

endmodule

// ===== sim/set_assoc_cache_lru_sim_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_tb
// Self-checking bench for the LRU cache model. A short table of access and
// register words runs first. Pinned totals check the cold start, and the rest
// is scored against a cycle-free cache predictor. Then come randomized phases
// over several geometries, with random idling on the access and result
// sides. Access addresses are mostly drawn from small tag/set pools, so hits
// and LRU evictions are frequent.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_tb
    import sacl_pkg::*;
();

    localparam int WAYS_MAX    = 8;
    localparam int SETS_LOG    = 6;
    localparam int LINES       = (1 << SETS_LOG) * WAYS_MAX;
    localparam int STAGES      = 10;
    localparam int STAGE_ITEMS = 135;
    localparam int STALL_LIMIT = 3000;
    localparam int PLAN_LEN    = 26;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;

    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        evict;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } outcome_t;

    typedef enum bit {ST_ACCESS, ST_REGWRITE} step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [CMD_W-1:0]       cmd;
        logic [31:0]            addr;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic                   pinned;
        outcome_t               want;
    } step_t;

    typedef struct packed {
        logic [2:0] sets;
        logic [4:0] blk;
        logic [3:0] ways;
    } geometry_t;

    localparam outcome_t NO_OUTCOME = '0;

    // cold start: totals can be read straight off the access sequence
    step_t plan [PLAN_LEN] = '{
        '{ST_ACCESS, CMD_FETCH, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
        '{ST_ACCESS, CMD_STORE, 32'hFFFF_FFFF, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b0, 1'b1, 1'b1, 32'd1, 32'd2, 32'd1}},
        '{ST_ACCESS, CMD_MODIFY, 32'hFFFF_FFFF, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 32'd3, 32'd2, 32'd1}},
        '{ST_ACCESS, CMD_MODIFY, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b0, 1'b1, 1'b1, 32'd4, 32'd3, 32'd2}},
        '{ST_ACCESS, CMD_FETCH, 32'hFFFF_FFFF, CFG_SET_BITS, 5'd0, 1'b1,
          '{1'b0, 1'b0, 1'b0, 32'd4, 32'd3, 32'd2}},
        // four ways, 16-byte blocks: fill one set, then walk the LRU order
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_WAYS_USED, 5'd4, 1'b0, NO_OUTCOME},
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_BLOCK_BITS, 5'd4, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0100, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0200, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_STORE, 32'h0000_0300, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0400, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_MODIFY, 32'h0000_0100, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        // shrink and regrow: lines beyond the used ways must survive
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_WAYS_USED, 5'd1, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_LOAD, 32'h0000_0000, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_WAYS_USED, 5'd4, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_STORE, 32'h0000_0300, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        // oversize set field and shifts past the address width
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_SET_BITS, 5'd7, 1'b0, NO_OUTCOME},
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_BLOCK_BITS, 5'd31, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_STORE, 32'hDEAD_BEEF, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_SET_BITS, 5'd4, 1'b0, NO_OUTCOME},
        '{ST_REGWRITE, CMD_LOAD, 32'h0, CFG_BLOCK_BITS, 5'd28, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_MODIFY, 32'hF000_0000, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME},
        '{ST_ACCESS, CMD_FETCH, 32'h1234_5678, CFG_SET_BITS, 5'd0, 1'b0, NO_OUTCOME}
    };

    geometry_t geometries [STAGES] = '{
        '{3'd2, 5'd4, 4'd4},
        '{3'd7, 5'd31, 4'd15},
        '{3'd0, 5'd0, 4'd0},
        '{3'd6, 5'd26, 4'd8},
        '{3'd3, 5'd2, 4'd2},
        '{3'd4, 5'd28, 4'd3},
        '{3'd5, 5'd3, 4'd9},
        '{3'd1, 5'd5, 4'd8},
        '{3'd6, 5'd0, 4'd8},
        '{3'd0, 5'd12, 4'd4}
    };

    logic clk = 1'b0;
    logic rst_n;

    sacl_access_if access_ch();
    sacl_result_if result_ch();
    sacl_cfg_if    cfg_ch();

    set_assoc_cache_lru_sim i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    bit          lru_valid [LINES];
    logic [31:0] lru_tag   [LINES];
    logic [31:0] lru_stamp [LINES];
    logic [31:0] stamp_now;
    logic [31:0] hits_seen;
    logic [31:0] misses_seen;
    logic [31:0] evicts_seen;
    logic [2:0]  shadow_set_bits;
    logic [4:0]  shadow_block_bits;
    logic [3:0]  shadow_ways;

    outcome_t    expected_outcomes [$];
    logic [31:0] tag_pool [12];
    logic [31:0] set_pool [2];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          quiet_cycles;

    function automatic int unsigned eff_set_bits();
        return (shadow_set_bits > SETS_LOG) ? SETS_LOG : shadow_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (shadow_ways == 0)
            return 1;
        return (shadow_ways > WAYS_MAX) ? WAYS_MAX : shadow_ways;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void refresh_line(int unsigned idx, logic [31:0] tag);
        stamp_now = stamp_now + 32'd1;
        if (stamp_now == 32'd0)
            stamp_now = 32'd1;
        lru_valid[idx] = 1'b1;
        lru_tag[idx]   = tag;
        lru_stamp[idx] = stamp_now;
    endfunction

    // one lookup into the set; returns hit, flags an LRU replacement
    function automatic bit probe_set(int unsigned set_idx, logic [31:0] tag,
                                     int unsigned nways, output bit evicted);
        int unsigned base;
        int unsigned w;
        int unsigned pick;
        base    = set_idx * WAYS_MAX;
        evicted = 1'b0;
        for (w = 0; w < nways; w++)
        begin
            if (lru_valid[base + w] && lru_tag[base + w] == tag)
            begin
                hits_seen = bump(hits_seen);
                refresh_line(base + w, tag);
                return 1'b1;
            end
        end
        misses_seen = bump(misses_seen);
        for (w = 0; w < nways; w++)
        begin
            if (!lru_valid[base + w])
            begin
                refresh_line(base + w, tag);
                return 1'b0;
            end
        end
        evicts_seen = bump(evicts_seen);
        evicted     = 1'b1;
        pick        = 0;
        for (w = 0; w < nways; w++)
        begin
            // a zero stamp wins outright, else oldest stamp, lowest way on ties
            if (lru_stamp[base + w] == 32'd0)
            begin
                pick = w;
                break;
            end
            if (lru_stamp[base + w] < lru_stamp[base + pick])
                pick = w;
        end
        refresh_line(base + pick, tag);
        return 1'b0;
    endfunction

    function automatic outcome_t predict_outcome(logic [CMD_W-1:0] cmd, logic [31:0] addr);
        int unsigned s;
        int unsigned nways;
        logic [31:0] set_idx;
        logic [31:0] tag;
        bit          ev;
        bit          ev2;
        bit          hit;
        outcome_t    o;
        s     = eff_set_bits();
        nways = eff_ways();
        o     = '0;
        if (cmd != CMD_FETCH)
        begin
            // shifts of 32 or more leave zero
            set_idx = (addr >> shadow_block_bits) & ((32'd1 << s) - 32'd1);
            tag     = addr >> (shadow_block_bits + s);
            hit     = probe_set(set_idx, tag, nways, ev);
            if (cmd == CMD_MODIFY)
                void'(probe_set(set_idx, tag, nways, ev2));
            o.hit   = hit;
            o.miss  = !hit;
            o.evict = ev;
        end
        o.hit_total   = hits_seen;
        o.miss_total  = misses_seen;
        o.evict_total = evicts_seen;
        return o;
    endfunction

    // mostly pooled tags/sets so that sets fill and evict; some raw addresses
    function automatic logic [31:0] pick_address();
        logic [63:0] a;
        logic [31:0] off;
        int unsigned s;
        int unsigned b;
        s   = eff_set_bits();
        b   = shadow_block_bits;
        off = $urandom();
        if ($urandom_range(0, 99) < 20)
            return $urandom();
        a = ({32'd0, tag_pool[$urandom_range(0, eff_ways() + 1)]} << (b + s))
          | ({32'd0, set_pool[$urandom_range(0, 1)] & ((32'd1 << s) - 32'd1)} << b)
          | ({32'd0, off} & ((64'd1 << b) - 64'd1));
        return a[31:0];
    endfunction

    task automatic send_access(logic [CMD_W-1:0] cmd, logic [31:0] addr,
                               bit pinned, outcome_t pinned_want);
        outcome_t o;
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid   <= 1'b1;
        access_ch.cmd     <= cmd;
        access_ch.address <= addr;
        forever
        begin
            @(posedge clk);
            if (access_ch.ready)
                break;
        end
        o = predict_outcome(cmd, addr);
        expected_outcomes.push_back(pinned ? pinned_want : o);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        case (idx)
            CFG_SET_BITS:   shadow_set_bits   = val[2:0];
            CFG_BLOCK_BITS: shadow_block_bits = val;
            CFG_WAYS_USED:  shadow_ways       = val[3:0];
            default: ;
        endcase
    endtask

    // park both request channels and wait for every pending word to return
    task automatic drain_results();
        access_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (expected_outcomes.size() == 0)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t ns: result word with nothing pending, expected none actual %0h",
                         $time, result_ch.hit_total);
                errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("was_hit", want.hit, result_ch.was_hit);
                check_field("was_miss", want.miss, result_ch.was_miss);
                check_field("did_evict", want.evict, result_ch.did_evict);
                check_field("hit_total", want.hit_total, result_ch.hit_total);
                check_field("miss_total", want.miss_total, result_ch.miss_total);
                check_field("evict_total", want.evict_total, result_ch.evict_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        int k;
        access_ch.valid   = 1'b0;
        access_ch.cmd     = CMD_LOAD;
        access_ch.address = 32'd0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_SET_BITS;
        cfg_ch.data       = 5'd0;
        result_ch.ready   = 1'b0;
        rst_n             = 1'b0;
        errors            = 0;
        quiet_cycles      = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        for (i = 0; i < LINES; i++)
        begin
            lru_valid[i] = 1'b0;
            lru_stamp[i] = 32'd0;
        end
        stamp_now         = 32'd1;
        hits_seen         = 32'd0;
        misses_seen       = 32'd0;
        evicts_seen       = 32'd0;
        shadow_set_bits   = 3'd0;
        shadow_block_bits = 5'd0;
        shadow_ways       = 4'd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, moderate idling on both sides
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ST_REGWRITE)
            begin
                drain_results();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_access(plan[i].cmd, plan[i].addr, plan[i].pinned, plan[i].want);
        end

        for (n = 0; n < STAGES; n++)
        begin
            drain_results();
            write_reg(CFG_SET_BITS, {2'b00, geometries[n].sets});
            write_reg(CFG_BLOCK_BITS, geometries[n].blk);
            write_reg(CFG_WAYS_USED, {1'b0, geometries[n].ways});
            case (n % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (k = 0; k < 12; k++)
                tag_pool[k] = $urandom();
            set_pool[0] = $urandom();
            set_pool[1] = $urandom();
            for (k = 0; k < STAGE_ITEMS; k++)
            begin
                if (k == STAGE_ITEMS / 2 && n % 3 == 1)
                    drain_results();
                send_access(2'($urandom_range(0, 3)), pick_address(), 1'b0, NO_OUTCOME);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
